[src/bode_pkg.sv]
// Shared types, constants and helpers of the braille ordered-dither encoder.
// Depends on nothing; imported by the top level and the checker.
package bode_pkg;

  localparam int PIXW  = 24;  // packed r g b
  localparam int SUMW  = 10;  // r+g+b, up to 765
  localparam int IDXW  = 17;  // col + row*cell_columns, up to 130560
  localparam int CFGW  = 9;
  localparam int NPIX  = 8;
  localparam logic [CFGW-1:0] CELL_COLUMNS_RST = 9'd80;

  localparam logic [15:0] CP_BASE    = 16'd10240;  // U+2800
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [7:0]  UTF8_MASK6 = 8'h3F;

  typedef logic [PIXW-1:0] pix_t;
  typedef logic [SUMW-1:0] sum_t;

  // 4x4 Bayer thresholds, row-major (y*4 + x)
  localparam logic [7:0] BAYER [16] = '{
    8'd0,   8'd128, 8'd32,  8'd160,
    8'd192, 8'd64,  8'd224, 8'd96,
    8'd48,  8'd176, 8'd16,  8'd144,
    8'd240, 8'd112, 8'd208, 8'd80
  };

  // braille dot bit for pixel (x, y), indexed x + 2*y
  localparam logic [2:0] DOT_BIT [8] = '{
    3'd0, 3'd3, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6, 3'd7
  };

  function automatic sum_t pix_sum(input pix_t pix);
    return SUMW'(pix[23:16]) + SUMW'(pix[15:8]) + SUMW'(pix[7:0]);
  endfunction

  // floor(s/3) > t  <=>  s >= 3t+3, so the dot test needs no divide
  function automatic sum_t dot_limit(input logic [1:0] lx, input logic [1:0] y);
    return SUMW'(3 * int'(BAYER[{y, lx}]) + 3);
  endfunction

endpackage

[src/braille_ordered_dither_encoder.sv]
// Top level of the braille ordered-dither encoder: four-stage pipeline and
// shown-pattern store. Depends on bode_pkg and bode_ram.
//
// Words pass stages 1, 2, 3 and the output register. Unless stalled, the
// throughput is one word per cycle; the store's read-modify-write is split
//   over read (stage 2 to 3) and write (stage 3 to 4) with one forward path.
// Reset (rst_n low, synchronous) clears control state and sets cell_columns
//   to 80, then a clearing pass over all MAX_CELLS addresses zeroes the
//   store while in_stall stays high; cfg writes are taken throughout.
module braille_ordered_dither_encoder
  import bode_pkg::*;
#(
  parameter int MAX_CELLS = 16384
) (
  input  logic            clk,
  input  logic            rst_n,
  // configuration
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CFGW-1:0] cfg_cell_columns,
  // input cells
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_cell_col,
  input  logic [7:0]      in_cell_row,
  input  pix_t            in_pix_l0,
  input  pix_t            in_pix_l1,
  input  pix_t            in_pix_l2,
  input  pix_t            in_pix_l3,
  input  pix_t            in_pix_r0,
  input  pix_t            in_pix_r1,
  input  pix_t            in_pix_r2,
  input  pix_t            in_pix_r3,
  // changed cells
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_col,
  output logic [7:0]      out_row,
  output logic [7:0]      out_dot_pattern,
  output logic [7:0]      out_utf8_lead,
  output logic [7:0]      out_utf8_mid,
  output logic [7:0]      out_utf8_last
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam logic [IDXW-1:0] CELL_LIMIT = IDXW'(MAX_CELLS);
  localparam logic [AW-1:0]   LAST_ADDR  = AW'(MAX_CELLS - 1);

  // ---------------- configuration ----------------
  logic [CFGW-1:0] cell_columns_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_columns_r <= CELL_COLUMNS_RST;
    end else if (cfg_valid && cfg_ready) begin
      cell_columns_r <= cfg_cell_columns;
    end
  end

  // ---------------- store clearing pass ----------------
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------- flow control ----------------
  // Each stage moves when it is empty or the one after it moves, so
  // bubbles collapse and a stalled output only backs up what is full.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !out_valid_r || !out_stall;
  assign rdy3     = !s3_valid_r || rdy4;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = clr_busy_r || !rdy1;

  logic in_take, s3_adv, s2_adv;
  assign in_take = in_valid && !in_stall;
  assign s2_adv  = s2_valid_r && rdy3;
  assign s3_adv  = s3_valid_r && rdy4;

  // ---------------- stage 1: pixel sums, row offset ----------------
  pix_t             pix_in [NPIX];
  sum_t             s1_sum_r [NPIX];
  logic [7:0]       s1_col_r, s1_row_r;
  logic [IDXW-1:0]  s1_prod_r;

  // order L0..L3, R0..R3: p = x*4 + y
  assign pix_in[0] = in_pix_l0;
  assign pix_in[1] = in_pix_l1;
  assign pix_in[2] = in_pix_l2;
  assign pix_in[3] = in_pix_l3;
  assign pix_in[4] = in_pix_r0;
  assign pix_in[5] = in_pix_r1;
  assign pix_in[6] = in_pix_r2;
  assign pix_in[7] = in_pix_r3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_col_r  <= in_cell_col;
      s1_row_r  <= in_cell_row;
      s1_prod_r <= IDXW'(in_cell_row) * IDXW'(cell_columns_r);
      for (int p = 0; p < NPIX; p++) begin
        s1_sum_r[p] <= pix_sum(pix_in[p]);
      end
    end
  end

  // ---------------- stage 2: dither, cell index ----------------
  logic [7:0]      s2_pat_nxt, s2_pat_r;
  logic [IDXW-1:0] s2_idx_nxt;
  logic [7:0]      s2_col_r, s2_row_r;
  logic [AW-1:0]   s2_addr_r;
  logic            s2_inr_r;

  // threshold column is (col*2 + x) mod 4 = {col[0], x}
  always_comb begin
    s2_pat_nxt = '0;
    for (int p = 0; p < NPIX; p++) begin
      s2_pat_nxt[DOT_BIT[(p % 4) * 2 + p / 4]] =
        (s1_sum_r[p] >= dot_limit({s1_col_r[0], p[2]}, p[1:0]));
    end
  end

  assign s2_idx_nxt = IDXW'(s1_col_r) + s1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && rdy2) begin
      s2_col_r  <= s1_col_r;
      s2_row_r  <= s1_row_r;
      s2_pat_r  <= s2_pat_nxt;
      s2_addr_r <= s2_idx_nxt[AW-1:0];
      s2_inr_r  <= (s2_idx_nxt < CELL_LIMIT);
    end
  end

  // ---------------- stage 3: compare with stored pattern ----------------
  logic [7:0]    s3_col_r, s3_row_r, s3_pat_r;
  logic [AW-1:0] s3_addr_r;
  logic          s3_inr_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_pat_r;
  logic [7:0]    ram_q, shown;
  logic          s3_changed;
  logic          item_we;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  // The only write that can race a read is the one at the same edge.
  assign shown      = fwd_hit_r ? fwd_pat_r : ram_q;
  assign s3_changed = s3_inr_r && (shown != s3_pat_r);
  assign item_we    = s3_adv && s3_changed;

  assign ram_we    = clr_busy_r || item_we;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s3_addr_r;
  assign ram_wdata = clr_busy_r ? 8'd0 : s3_pat_r;

  bode_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s2_adv),
    .raddr (s2_addr_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (rdy3) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_col_r  <= s2_col_r;
      s3_row_r  <= s2_row_r;
      s3_pat_r  <= s2_pat_r;
      s3_addr_r <= s2_addr_r;
      s3_inr_r  <= s2_inr_r;
      fwd_hit_r <= item_we && (s3_addr_r == s2_addr_r);
      fwd_pat_r <= s3_pat_r;
    end
  end

  // ---------------- stage 4: output register ----------------
  logic [7:0]  out_col_r, out_row_r, out_pat_r;
  logic [7:0]  out_lead_r, out_mid_r, out_last_r;
  logic [15:0] cp;

  assign cp = CP_BASE + 16'(s3_pat_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy4) begin
      out_valid_r <= s3_valid_r && s3_changed;
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      out_col_r  <= s3_col_r;
      out_row_r  <= s3_row_r;
      out_pat_r  <= s3_pat_r;
      out_lead_r <= UTF8_LEAD3 | 8'(cp >> 12);
      out_mid_r  <= UTF8_CONT | (8'(cp >> 6) & UTF8_MASK6);
      out_last_r <= UTF8_CONT | (cp[7:0] & UTF8_MASK6);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_col         = out_col_r;
  assign out_row         = out_row_r;
  assign out_dot_pattern = out_pat_r;
  assign out_utf8_lead   = out_lead_r;
  assign out_utf8_mid    = out_mid_r;
  assign out_utf8_last   = out_last_r;

endmodule

[src/bode_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bode_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/bode_checker.sv]
// Port-level checks of the braille ordered-dither encoder, bound to the top.
// Depends on bode_pkg and braille_ordered_dither_encoder.
module bode_checker
  import bode_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic [7:0]      out_col,
  input logic [7:0]      out_row,
  input logic [7:0]      out_dot_pattern,
  input logic [7:0]      out_utf8_lead,
  input logic [7:0]      out_utf8_mid,
  input logic [7:0]      out_utf8_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_col) && $stable(out_row)
      && $stable(out_dot_pattern) && $stable(out_utf8_last))
    else $error("stalled output word changed");

  // bytes always encode U+2800 + dot_pattern
  a_utf8: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_utf8_lead == 8'hE2 && out_utf8_mid[7:2] == 6'b101000
      && out_utf8_last[7:6] == 2'b10
      && {out_utf8_mid[1:0], out_utf8_last[5:0]} == out_dot_pattern)
    else $error("utf8 bytes do not match dot pattern");

  // reset empties the pipe and starts the store clear
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input open or output valid right after reset");

endmodule

bind braille_ordered_dither_encoder bode_checker u_bode_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_col         (out_col),
  .out_row         (out_row),
  .out_dot_pattern (out_dot_pattern),
  .out_utf8_lead   (out_utf8_lead),
  .out_utf8_mid    (out_utf8_mid),
  .out_utf8_last   (out_utf8_last)
);
